// ===== rtl/obs_pkg.sv =====
// Shared types and constants for the offset-and-bit-split unit.
// No dependencies; every other file refers to it by scoped names.
package obs_pkg;

    localparam int DATA_W = 32;   // sample and base width
    localparam int PART_W = 16;   // high/low part width
    localparam int WID_W  = 5;    // width fields, 0..16
    localparam int BLEN_W = 6;    // bit length of a 32-bit span, 0..32

    typedef logic [DATA_W-1:0] t_word;

    // result handed back by the bit-length unit
    typedef struct packed {
        logic              done;
        logic [BLEN_W-1:0] len;
    } t_blen_res;

endpackage

// ===== rtl/obs_if.sv =====
// Valid/ready channel interfaces for the offset-and-bit-split unit.
// Depends on obs_pkg for field widths.
interface obs_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [obs_pkg::DATA_W-1:0] sample;
    logic                              final_in;

    modport source (output valid, sample, final_in, input ready);
    modport sink   (input valid, sample, final_in, output ready);
endinterface

interface obs_out_if;
    logic                              valid;
    logic                              ready;
    logic        [obs_pkg::PART_W-1:0] high_part;
    logic        [obs_pkg::PART_W-1:0] low_part;
    logic signed [obs_pkg::DATA_W-1:0] base_offset;
    logic        [obs_pkg::WID_W-1:0]  high_width;
    logic        [obs_pkg::WID_W-1:0]  low_width;
    logic                              dropped;
    logic                              final_out;

    modport source (output valid, high_part, low_part, base_offset, high_width,
                    low_width, dropped, final_out, input ready);
    modport sink   (input valid, high_part, low_part, base_offset, high_width,
                    low_width, dropped, final_out, output ready);
endinterface

// ===== rtl/obs_cell.sv =====
// One storage cell of the value chain: loads a sample when selected,
// takes its neighbor's value on a shift. Depends on obs_pkg.
module obs_cell (
    input  logic           i_clk,
    input  logic           i_load,
    input  logic           i_shift,
    input  obs_pkg::t_word i_sample,
    input  obs_pkg::t_word i_next,
    output obs_pkg::t_word o_value
);

    obs_pkg::t_word r_value;
    obs_pkg::t_word n_value;

    always_comb begin
        n_value = r_value;
        if (i_load) begin
            n_value = i_sample;
        end else if (i_shift) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/obs_blen.sv =====
// Iterative bit-length unit: shifts the span right one bit per cycle
// and counts until it is zero. Depends on obs_pkg.
module obs_blen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  obs_pkg::t_word     i_span,
    output obs_pkg::t_blen_res o_res
);

    logic                      r_busy;
    logic                      n_busy;
    obs_pkg::t_word            r_val;
    obs_pkg::t_word            n_val;
    logic [obs_pkg::BLEN_W-1:0] r_cnt;
    logic [obs_pkg::BLEN_W-1:0] n_cnt;

    always_comb begin
        n_busy = r_busy;
        n_val  = r_val;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_val  = i_span;
            n_cnt  = '0;
        end else if (r_busy) begin
            if (r_val != '0) begin
                n_val = r_val >> 1;
                n_cnt = r_cnt + 1'b1;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_val <= n_val;
        r_cnt <= n_cnt;
    end

    assign o_res.done = r_busy && (r_val == '0);
    assign o_res.len  = r_cnt;

endmodule

// ===== rtl/offset_and_bit_split_unit.sv =====
// Offset-and-bit-split unit. Takes one sample per cycle into a chain of
// MAX_ITEMS cells while tracking min and max; samples beyond capacity are
// dropped and flagged. After the final sample input stalls: a state forms
// the span, the shift-and-count bit-length unit finds its bit length (up to
// 32), then one result per stored value leaves per cycle while the receiver
// is ready, read from the head cell as the chain shifts.
// Depends on obs_pkg, obs_if, obs_cell and obs_blen.
module offset_and_bit_split_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    obs_in_if.sink    i_in,
    obs_out_if.source o_out
);

    localparam int FILL_W = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SPAN = 2'd1;
    localparam logic [1:0] S_BLEN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam obs_pkg::t_word MIN_RST = {1'b0, {(obs_pkg::DATA_W-1){1'b1}}};
    localparam obs_pkg::t_word MAX_RST = {1'b1, {(obs_pkg::DATA_W-1){1'b0}}};

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [FILL_W-1:0]         r_fill;
    logic [FILL_W-1:0]         n_fill;
    logic [FILL_W-1:0]         r_left;
    logic [FILL_W-1:0]         n_left;
    obs_pkg::t_word            r_min;
    obs_pkg::t_word            n_min;
    obs_pkg::t_word            r_max;
    obs_pkg::t_word            n_max;
    logic                      r_ovf;
    logic                      n_ovf;
    logic [obs_pkg::WID_W-1:0] r_lw;
    logic [obs_pkg::WID_W-1:0] n_lw;
    logic [obs_pkg::WID_W-1:0] r_hw;
    logic [obs_pkg::WID_W-1:0] n_hw;

    logic                       r_oval;
    logic                       n_oval;
    logic [obs_pkg::PART_W-1:0] r_ohigh;
    logic [obs_pkg::PART_W-1:0] r_olow;
    obs_pkg::t_word             r_obase;
    logic [obs_pkg::WID_W-1:0]  r_ohw;
    logic [obs_pkg::WID_W-1:0]  r_olw;
    logic                       r_odrop;
    logic                       r_ofinal;

    logic               w_accept;
    logic               w_store;
    logic               w_adv;
    obs_pkg::t_word     w_span;
    obs_pkg::t_word     w_off;
    obs_pkg::t_word     w_mask;
    obs_pkg::t_blen_res w_blen;
    obs_pkg::t_word     w_cell [MAX_ITEMS];

    assign i_in.ready = (r_state == S_LOAD);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_store    = w_accept && (r_fill != FILL_W'(MAX_ITEMS));
    assign w_adv      = (r_state == S_EMIT) && (r_left != '0) && (!r_oval || o_out.ready);
    assign w_span     = r_max - r_min;

    // value chain: a sample lands in the cell at the fill index; emission
    // shifts everything one cell toward the head
    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        obs_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (w_store && (r_fill == FILL_W'(k))),
            .i_shift  (w_adv),
            .i_sample (i_in.sample),
            .i_next   (w_cell[(k == MAX_ITEMS - 1) ? k : k + 1]),
            .o_value  (w_cell[k])
        );
    end

    obs_blen u_blen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SPAN),
        .i_span  (w_span),
        .o_res   (w_blen)
    );

    assign w_off  = w_cell[0] - r_min;
    assign w_mask = (obs_pkg::DATA_W'(1) << r_lw) - obs_pkg::DATA_W'(1);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_left  = r_left;
        n_min   = r_min;
        n_max   = r_max;
        n_ovf   = r_ovf;
        n_lw    = r_lw;
        n_hw    = r_hw;
        n_oval  = r_oval && !o_out.ready;
        case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (w_store) begin
                        n_fill = r_fill + 1'b1;
                        if ($signed(i_in.sample) < $signed(r_min)) begin
                            n_min = i_in.sample;
                        end
                        if ($signed(i_in.sample) > $signed(r_max)) begin
                            n_max = i_in.sample;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.final_in) begin
                        n_state = S_SPAN;
                    end
                end
            end
            S_SPAN: begin
                n_state = S_BLEN;
            end
            S_BLEN: begin
                if (w_blen.done) begin
                    n_lw    = obs_pkg::WID_W'(w_blen.len >> 1);
                    n_hw    = obs_pkg::WID_W'(w_blen.len - (w_blen.len >> 1));
                    n_left  = r_fill;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_adv) begin
                    n_oval = 1'b1;
                    n_left = r_left - 1'b1;
                end else if (r_left == '0) begin
                    n_fill  = '0;
                    n_min   = MIN_RST;
                    n_max   = MAX_RST;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_left  <= '0;
            r_min   <= MIN_RST;
            r_max   <= MAX_RST;
            r_ovf   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_min   <= n_min;
            r_max   <= n_max;
            r_ovf   <= n_ovf;
            r_oval  <= n_oval;
        end
        r_lw <= n_lw;
        r_hw <= n_hw;
        if (w_adv) begin
            r_ohigh  <= obs_pkg::PART_W'(w_off >> r_lw);
            r_olow   <= obs_pkg::PART_W'(w_off & w_mask);
            r_obase  <= r_min;
            r_ohw    <= r_hw;
            r_olw    <= r_lw;
            r_odrop  <= r_ovf;
            r_ofinal <= (r_left == FILL_W'(1));
        end
    end

    assign o_out.valid       = r_oval;
    assign o_out.high_part   = r_ohigh;
    assign o_out.low_part    = r_olow;
    assign o_out.base_offset = r_obase;
    assign o_out.high_width  = r_ohw;
    assign o_out.low_width   = r_olw;
    assign o_out.dropped     = r_odrop;
    assign o_out.final_out   = r_ofinal;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_fill == FILL_W'(MAX_ITEMS)))
        else $error("overflow flagged with room left");

    a_blen_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_blen.done && (r_state != S_SPAN)) |-> (r_state == S_BLEN))
        else $error("bit length finished outside its phase");

    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_left == '0 && !w_adv) |=> (r_fill == '0 && !r_ovf))
        else $error("block state not cleared after emission");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_left == FILL_W'(1)) |=> (r_ofinal && r_left == '0))
        else $error("last result not marked final");

endmodule

// ===== bench/obs_split_checker.sv =====
// Scoreboard for the offset-and-bit-split unit: watches both channels, predicts
// the split results of every block and compares them with what the unit emits.
// Depends on obs_pkg and the channel interfaces in obs_if.
module obs_split_checker #(
    parameter int MAX_ITEMS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    obs_in_if    i_in_mon,
    obs_out_if   i_out_mon,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [obs_pkg::DATA_W-1:0] t_sword;

    typedef struct packed {
        logic [obs_pkg::PART_W-1:0] high_part;
        logic [obs_pkg::PART_W-1:0] low_part;
        t_sword                     base_offset;
        logic [obs_pkg::WID_W-1:0]  high_width;
        logic [obs_pkg::WID_W-1:0]  low_width;
        logic                       dropped;
        logic                       final_out;
    } t_split_result;

    // predictor state for the block being loaded
    obs_pkg::t_word sample_mem [MAX_ITEMS];
    int             fill_cnt;
    t_sword         blk_min;
    t_sword         blk_max;
    logic           spilled;

    t_split_result  split_q [$];
    int             mismatches;
    int             checked;

    task automatic clear_block();
        fill_cnt = 0;
        blk_min  = 32'sh7FFF_FFFF;
        blk_max  = 32'sh8000_0000;
        spilled  = 1'b0;
    endtask

    task automatic predict_split(input t_sword s, input logic fin);
        obs_pkg::t_word span;
        obs_pkg::t_word off;
        obs_pkg::t_word low_mask;
        int unsigned    nbits;
        int unsigned    lw;
        t_split_result  r;
        if (fill_cnt < MAX_ITEMS) begin
            sample_mem[fill_cnt] = s;
            fill_cnt++;
            if (s < blk_min) blk_min = s;
            if (s > blk_max) blk_max = s;
        end else begin
            spilled = 1'b1;
        end
        if (fin) begin
            span  = blk_max - blk_min;
            nbits = 0;
            while (span != 0) begin
                span = span >> 1;
                nbits++;
            end
            lw       = nbits / 2;
            low_mask = (32'h1 << lw) - 32'h1;
            for (int i = 0; i < fill_cnt; i++) begin
                off           = sample_mem[i] - blk_min;
                r.high_part   = obs_pkg::PART_W'(off >> lw);
                r.low_part    = obs_pkg::PART_W'(off & low_mask);
                r.base_offset = blk_min;
                r.high_width  = obs_pkg::WID_W'(nbits - lw);
                r.low_width   = obs_pkg::WID_W'(lw);
                r.dropped     = spilled;
                r.final_out   = (i == fill_cnt - 1);
                split_q.push_back(r);
            end
            clear_block();
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("[%0t] %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        t_split_result got;
        t_split_result want;
        got.high_part   = i_out_mon.high_part;
        got.low_part    = i_out_mon.low_part;
        got.base_offset = i_out_mon.base_offset;
        got.high_width  = i_out_mon.high_width;
        got.low_width   = i_out_mon.low_width;
        got.dropped     = i_out_mon.dropped;
        got.final_out   = i_out_mon.final_out;
        if (split_q.size() == 0) begin
            mismatches++;
            $display("[%0t] unexpected result: expected none, got %h", $time, got);
        end else begin
            want = split_q.pop_front();
            checked++;
            compare_field("high_part", 32'(want.high_part), 32'(got.high_part));
            compare_field("low_part", 32'(want.low_part), 32'(got.low_part));
            compare_field("base_offset", want.base_offset, got.base_offset);
            compare_field("high_width", 32'(want.high_width), 32'(got.high_width));
            compare_field("low_width", 32'(want.low_width), 32'(got.low_width));
            compare_field("dropped", 32'(want.dropped), 32'(got.dropped));
            compare_field("final_out", 32'(want.final_out), 32'(got.final_out));
        end
    endtask

    initial begin
        mismatches = 0;
        checked    = 0;
        clear_block();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_block();
            split_q.delete();
        end else begin
            // results first: a block's own results can never leave in its final cycle
            if (i_out_mon.valid && i_out_mon.ready) check_result();
            if (i_in_mon.valid && i_in_mon.ready)
                predict_split(i_in_mon.sample, i_in_mon.final_in);
        end
        o_pending    <= split_q.size();
        o_mismatches <= mismatches;
        o_checked    <= checked;
    end

endmodule

// ===== bench/tb.sv =====
// Top of the offset-and-bit-split bench: clock, reset, sample stimulus with
// bursty input and a stalling receiver, watchdog and verdict.
// Depends on obs_pkg, obs_if, the unit itself and obs_split_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS      = 64;
    localparam int RANDOM_ITEMS   = 400;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    obs_in_if  in_ch ();
    obs_out_if out_ch ();

    int mismatches;
    int pending;
    int checked;

    obs_pkg::t_word block_q [$];
    int             burst_left     = 0;
    int             stored_samples = 0;
    int             blocks         = 0;
    int             overflow_blocks = 0;
    int             holds_done     = 0;
    int             idle_cycles    = 0;
    logic           hold_req       = 1'b0;

    offset_and_bit_split_unit #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    obs_split_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one transaction on the sample channel; valid stays up across a burst
    task automatic send_sample(input obs_pkg::t_word s, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid    <= 1'b0;
                in_ch.sample   <= $urandom;
                in_ch.final_in <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.sample   <= s;
        in_ch.final_in <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_block();
        for (int i = 0; i < block_q.size(); i++) begin
            send_sample(block_q[i], i == block_q.size() - 1);
            if (i < MAX_ITEMS) stored_samples++;
        end
        blocks++;
        if (block_q.size() > MAX_ITEMS) overflow_blocks++;
    endtask

    task automatic build_random_block();
        int             kind;
        int             len;
        int             vstyle;
        int             rbits;
        obs_pkg::t_word base;
        obs_pkg::t_word span_mask;
        obs_pkg::t_word v;
        kind = $urandom_range(0, 19);
        if (kind < 12)      len = $urandom_range(1, 12);
        else if (kind < 15) len = $urandom_range(13, 40);
        else if (kind < 17) len = $urandom_range(41, MAX_ITEMS);
        else if (kind == 17) len = MAX_ITEMS;
        else                len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
        vstyle = $urandom_range(0, 3);
        rbits  = (vstyle == 3) ? $urandom_range(1, 4) : $urandom_range(0, 32);
        span_mask = (rbits == 0) ? '0 : (32'hFFFF_FFFF >> (32 - rbits));
        base   = $urandom;
        block_q.delete();
        for (int i = 0; i < len; i++) begin
            case (vstyle)
                0: v = $urandom;
                2: begin
                    case ($urandom_range(0, 4))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'h0000_0000;
                        3: v = 32'hFFFF_FFFF;
                        default: v = $urandom;
                    endcase
                end
                default: v = base + ($urandom & span_mask);
            endcase
            block_q.push_back(v);
        end
    endtask

    // receiver: segments of differing stall density, plus requested long hold-offs
    initial begin
        int mode;
        int len;
        out_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            repeat (len) begin
                if (hold_req) begin
                    hold_req = 1'b0;
                    out_ch.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    holds_done++;
                end
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    2: out_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   random_start;
        logic second_hold;
        in_ch.valid    <= 1'b0;
        in_ch.sample   <= '0;
        in_ch.final_in <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed blocks
        block_q = '{32'h7FFF_FFFF};                  // lone maximum, zero span
        send_block();
        block_q = '{32'h8000_0000, 32'h7FFF_FFFF};   // full range, both widths 16
        send_block();
        block_q = '{32'h0000_0000, 32'h0000_0001};   // one-bit span, low width 0
        send_block();
        block_q = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_block();
        block_q = '{32'h8000_0000};                  // lone minimum
        send_block();
        block_q = '{32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_03E8, 32'h8000_0001,
                    32'h0000_0007};
        send_block();
        block_q = '{32'h0000_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h7FFF_0000,
                    32'hAAAA_5555};
        send_block();

        // random blocks, with long receiver hold-offs at the start and midway
        random_start = stored_samples;
        second_hold  = 1'b0;
        hold_req     = 1'b1;
        while (stored_samples - random_start < RANDOM_ITEMS) begin
            if (!second_hold && stored_samples - random_start >= RANDOM_ITEMS / 2) begin
                second_hold = 1'b1;
                hold_req    = 1'b1;
            end
            build_random_block();
            send_block();
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending != 0)
            $display("[%0t] %0d expected results never arrived", $time, pending);
        $display("Run covered %0d stored samples in %0d blocks, %0d over capacity.",
                 stored_samples, blocks, overflow_blocks);
        $display("%0d results checked, %0d mismatches, %0d long receiver hold-offs.",
                 checked, mismatches, holds_done);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
